[sv/sss_pkg.sv]
// Shared types and constants for the segment span scanner.
// Used by sss_scan, sss_square, sss_total and segment_span_scanner.
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

	localparam int MAX_SEQ_LEN = 65536;
	localparam int POS_W       = $clog2(MAX_SEQ_LEN + 1);
	localparam int ID_W        = 31;
	localparam int TOK_W       = 32;
	localparam int OFF_W       = 31;
	localparam int MASK_W      = 31;
	localparam int SPAN_B_W    = 17;
	localparam int SPAN_F_W    = 18;
	localparam int STATUS_W    = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int SQ_W        = 2 * POS_W;
	localparam int SUM_W       = ((SQ_W > MASK_W) ? SQ_W : MASK_W) + 1;
	localparam int NEXT_W      = OFF_W + 1;

	localparam logic [MASK_W-1:0] MASK_SAT = '1;
	localparam logic [OFF_W-1:0]  OFF_SAT  = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MARKER    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_MULTI     = 3'd1,
		ST_BAD_SPAN  = 3'd2,
		ST_MASK_OVF  = 3'd3,
		ST_TOO_LONG  = 3'd4,
		ST_EQUAL_IDS = 3'd5
	} sss_status_t;

	// Summary of one finished sequence, produced by the scanner.
	typedef struct packed {
		logic [POS_W-1:0] len;
		logic             mk_found;
		logic [POS_W-1:0] mk_pos;
		logic             sep_found;
		logic [POS_W-1:0] sep_end;
		logic             extra;
		logic             too_long;
		logic             eq_ids;
	} sss_seq_t;

	// Sequence summary with the squared length and the span check.
	typedef struct packed {
		sss_seq_t         seq;
		logic             bad_span;
		logic [SQ_W-1:0]  sq;
	} sss_sq_t;

endpackage

`default_nettype wire

[sv/sss_scan.sv]
// Token scanner: holds the configuration registers and the per-sequence
// state, and registers a sequence summary on each last token. Uses sss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sss_scan (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sss_pkg::ID_W-1:0]      cfg_data,
	input  wire logic                          token_valid,
	output logic                               token_ready,
	input  wire logic [sss_pkg::TOK_W-1:0]     token_id,
	input  wire logic                          last_token,
	output logic                               seq_valid,
	input  wire logic                          seq_ready,
	output sss_pkg::sss_seq_t                  seq
);

	logic [sss_pkg::ID_W-1:0]  marker_id_q;
	logic [sss_pkg::ID_W-1:0]  separator_id_q;
	logic [sss_pkg::POS_W-1:0] position_q;
	logic                      mk_found_q;
	logic [sss_pkg::POS_W-1:0] mk_pos_q;
	logic                      sep_found_q;
	logic [sss_pkg::POS_W-1:0] sep_end_q;
	logic                      extra_q;
	logic                      too_long_q;
	logic                      eq_ids_q;
	logic                      seq_valid_q;
	sss_pkg::sss_seq_t         seq_s1;

	logic    accept;
	logic    in_range;
	logic    is_marker;
	logic    is_separator;
	logic    new_marker;
	logic    new_separator;
	sss_pkg::sss_seq_t nxt;

	assign token_ready = !seq_valid_q || seq_ready;
	assign accept      = token_valid && token_ready;
	assign seq_valid   = seq_valid_q;
	assign seq         = seq_s1;

	always_comb begin
		// Negative ids never match, since the registers are only 31 bits wide.
		in_range      = position_q < sss_pkg::POS_W'(sss_pkg::MAX_SEQ_LEN);
		is_marker     = !token_id[sss_pkg::TOK_W-1] &&
			(token_id[sss_pkg::ID_W-1:0] == marker_id_q);
		is_separator  = !token_id[sss_pkg::TOK_W-1] &&
			(token_id[sss_pkg::ID_W-1:0] == separator_id_q);
		new_marker    = in_range && is_marker && !mk_found_q;
		new_separator = in_range && !is_marker && mk_found_q && !sep_found_q &&
			is_separator;

		nxt.len       = in_range ? position_q + 1'b1 : position_q;
		nxt.mk_found  = mk_found_q || (in_range && is_marker);
		nxt.mk_pos    = new_marker ? position_q : mk_pos_q;
		nxt.sep_found = sep_found_q || new_separator;
		nxt.sep_end   = new_separator ? position_q + 1'b1 : sep_end_q;
		nxt.extra     = extra_q || (in_range && is_marker && mk_found_q);
		nxt.too_long  = too_long_q || !in_range;
		nxt.eq_ids    = eq_ids_q || (marker_id_q == separator_id_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_id_q    <= '0;
			separator_id_q <= sss_pkg::ID_W'(1);
			position_q     <= '0;
			mk_found_q     <= 1'b0;
			sep_found_q    <= 1'b0;
			extra_q        <= 1'b0;
			too_long_q     <= 1'b0;
			eq_ids_q       <= 1'b0;
			seq_valid_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					sss_pkg::CFG_MARKER:    marker_id_q    <= cfg_data;
					sss_pkg::CFG_SEPARATOR: separator_id_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept && last_token) begin
				seq_valid_q <= 1'b1;
			end else if (seq_ready) begin
				seq_valid_q <= 1'b0;
			end
			if (accept) begin
				if (last_token) begin
					position_q  <= '0;
					mk_found_q  <= 1'b0;
					sep_found_q <= 1'b0;
					extra_q     <= 1'b0;
					too_long_q  <= 1'b0;
					eq_ids_q    <= 1'b0;
				end else begin
					position_q  <= nxt.len;
					mk_found_q  <= nxt.mk_found;
					sep_found_q <= nxt.sep_found;
					extra_q     <= nxt.extra;
					too_long_q  <= nxt.too_long;
					eq_ids_q    <= nxt.eq_ids;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mk_pos_q  <= nxt.mk_pos;
			sep_end_q <= nxt.sep_end;
		end
		if (accept && last_token) begin
			seq_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

[sv/sss_square.sv]
// Squares the sequence length and checks the span against the length.
// Uses sss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sss_square (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               seq_valid,
	output logic                    seq_ready,
	input  wire sss_pkg::sss_seq_t  seq,
	output logic                    sq_valid,
	input  wire logic               sq_ready,
	output sss_pkg::sss_sq_t        sq
);

	logic                     sq_valid_q;
	sss_pkg::sss_sq_t         sq_s2;
	logic [sss_pkg::SQ_W-1:0] len_sq;
	logic                     bad_span;
	logic                     take;

	assign seq_ready = !sq_valid_q || sq_ready;
	assign take      = seq_valid && seq_ready;
	assign sq_valid  = sq_valid_q;
	assign sq        = sq_s2;

	always_comb begin
		len_sq   = {{sss_pkg::POS_W{1'b0}}, seq.len} * {{sss_pkg::POS_W{1'b0}}, seq.len};
		// A span that covers the whole sequence is as bad as a missing separator.
		bad_span = seq.mk_found &&
			(!seq.sep_found || ((seq.sep_end - seq.mk_pos) == seq.len));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_valid_q <= 1'b0;
		end else if (take) begin
			sq_valid_q <= 1'b1;
		end else if (sq_ready) begin
			sq_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sq_s2.seq      <= seq;
			sq_s2.bad_span <= bad_span;
			sq_s2.sq       <= len_sq;
		end
	end

endmodule

`default_nettype wire

[sv/sss_total.sv]
// Running totals: mask sum, packed offset, sticky flag and status, plus the
// result register. Uses sss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sss_total (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sq_valid,
	output logic                                   sq_ready,
	input  wire sss_pkg::sss_sq_t                  sq,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output logic        [sss_pkg::OFF_W-1:0]       sequence_offset,
	output logic        [sss_pkg::OFF_W-1:0]       profile_offset,
	output logic signed [sss_pkg::SPAN_B_W-1:0]    span_begin,
	output logic signed [sss_pkg::SPAN_F_W-1:0]    span_finish,
	output logic        [sss_pkg::MASK_W-1:0]      mask_total,
	output logic                                   any_profile,
	output logic        [sss_pkg::STATUS_W-1:0]    status
);

	logic [sss_pkg::MASK_W-1:0] mask_q;
	logic [sss_pkg::OFF_W-1:0]  offset_q;
	logic                       seen_q;
	sss_pkg::sss_status_t       err_q;
	logic                       result_valid_q;

	logic [sss_pkg::OFF_W-1:0]    seq_off_q;
	logic [sss_pkg::OFF_W-1:0]    prof_off_q;
	logic [sss_pkg::SPAN_B_W-1:0] span_b_q;
	logic [sss_pkg::SPAN_F_W-1:0] span_f_q;

	logic                        take;
	logic [sss_pkg::SUM_W-1:0]   sum;
	logic                        overflow;
	logic [sss_pkg::MASK_W-1:0]  mask_nxt;
	logic [sss_pkg::NEXT_W-1:0]  off_sum;
	logic [sss_pkg::OFF_W-1:0]   off_nxt;
	logic [sss_pkg::OFF_W-1:0]   prof_nxt;
	sss_pkg::sss_status_t        seq_err;
	sss_pkg::sss_status_t        err_nxt;

	assign sq_ready        = !result_valid_q || result_ready;
	assign take            = sq_valid && sq_ready;
	assign result_valid    = result_valid_q;
	assign sequence_offset = seq_off_q;
	assign profile_offset  = prof_off_q;
	assign span_begin      = span_b_q;
	assign span_finish     = span_f_q;
	// The totals change only when a result is loaded, so they double as outputs.
	assign mask_total      = mask_q;
	assign any_profile     = seen_q;
	assign status          = err_q;

	always_comb begin
		sum      = sss_pkg::SUM_W'(mask_q) + sss_pkg::SUM_W'(sq.sq);
		overflow = sum > sss_pkg::SUM_W'(sss_pkg::MASK_SAT);
		mask_nxt = overflow ? sss_pkg::MASK_SAT : sum[sss_pkg::MASK_W-1:0];

		off_sum  = sss_pkg::NEXT_W'(offset_q) + sss_pkg::NEXT_W'(sq.seq.len);
		off_nxt  = off_sum[sss_pkg::OFF_W] ? sss_pkg::OFF_SAT : off_sum[sss_pkg::OFF_W-1:0];
		// The profile offset wraps rather than saturates.
		prof_nxt = sq.seq.mk_found ? offset_q + sss_pkg::OFF_W'(sq.seq.mk_pos) : offset_q;

		// Equal ids are noted on the token itself, ahead of the end-of-sequence checks,
		// so they rank first.
		if (sq.seq.eq_ids) begin
			seq_err = sss_pkg::ST_EQUAL_IDS;
		end else if (sq.seq.too_long) begin
			seq_err = sss_pkg::ST_TOO_LONG;
		end else if (overflow) begin
			seq_err = sss_pkg::ST_MASK_OVF;
		end else if (sq.seq.extra) begin
			seq_err = sss_pkg::ST_MULTI;
		end else if (sq.bad_span) begin
			seq_err = sss_pkg::ST_BAD_SPAN;
		end else begin
			seq_err = sss_pkg::ST_OK;
		end
		err_nxt = (err_q == sss_pkg::ST_OK) ? seq_err : err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q         <= '0;
			offset_q       <= '0;
			seen_q         <= 1'b0;
			err_q          <= sss_pkg::ST_OK;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				result_valid_q <= 1'b1;
				mask_q         <= mask_nxt;
				offset_q       <= off_nxt;
				seen_q         <= seen_q || sq.seq.mk_found;
				err_q          <= err_nxt;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			seq_off_q  <= offset_q;
			prof_off_q <= prof_nxt;
			span_b_q   <= sq.seq.mk_found ? sss_pkg::SPAN_B_W'(sq.seq.mk_pos) : '1;
			span_f_q   <= sq.seq.sep_found ? sss_pkg::SPAN_F_W'(sq.seq.sep_end) : '1;
		end
	end

endmodule

`default_nettype wire

[sv/segment_span_scanner.sv]
// Three registered stages, scanner, squarer and totals, take the result in
// turn after the edge that accepts the last token. Throughput: one token per
// cycle while token_ready is high; a result per sequence, one per cycle at most.
// Reset clears the sequence state, totals, status and valids; the marker id
// resets to 0 and the separator id to 1.
`timescale 1ns / 1ps
`default_nettype none

module segment_span_scanner (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [sss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sss_pkg::ID_W-1:0]          cfg_data,
	input  wire logic                              token_valid,
	output logic                                   token_ready,
	input  wire logic signed [sss_pkg::TOK_W-1:0]  token_id,
	input  wire logic                              last_token,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output logic        [sss_pkg::OFF_W-1:0]       sequence_offset,
	output logic        [sss_pkg::OFF_W-1:0]       profile_offset,
	output logic signed [sss_pkg::SPAN_B_W-1:0]    span_begin,
	output logic signed [sss_pkg::SPAN_F_W-1:0]    span_finish,
	output logic        [sss_pkg::MASK_W-1:0]      mask_total,
	output logic                                   any_profile,
	output logic        [sss_pkg::STATUS_W-1:0]    status
);

	logic              seq_valid;
	logic              seq_ready;
	sss_pkg::sss_seq_t seq;
	logic              sq_valid;
	logic              sq_ready;
	sss_pkg::sss_sq_t  sq;

	sss_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_id    (token_id),
		.last_token  (last_token),
		.seq_valid   (seq_valid),
		.seq_ready   (seq_ready),
		.seq         (seq)
	);

	sss_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.seq_valid (seq_valid),
		.seq_ready (seq_ready),
		.seq       (seq),
		.sq_valid  (sq_valid),
		.sq_ready  (sq_ready),
		.sq        (sq)
	);

	sss_total u_total (
		.clk             (clk),
		.arst_n          (arst_n),
		.sq_valid        (sq_valid),
		.sq_ready        (sq_ready),
		.sq              (sq),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.sequence_offset (sequence_offset),
		.profile_offset  (profile_offset),
		.span_begin      (span_begin),
		.span_finish     (span_finish),
		.mask_total      (mask_total),
		.any_profile     (any_profile),
		.status          (status)
	);

`ifndef SYNTHESIS
	// Once an error is recorded it never changes.
	a_status_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(status != sss_pkg::ST_OK) |=> (status == $past(status)))
		else $error("status changed after an error was recorded");

	// The saturating mask total never goes down.
	a_mask_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (mask_total >= $past(mask_total)))
		else $error("mask total decreased");

	// A separator is only found after a marker, so the span ends past its start.
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (span_finish != '1)) |->
		((span_begin != '1) && (span_finish > span_begin)))
		else $error("span end found without a valid span start");
`endif

endmodule

`default_nettype wire
